>>> rtl/npim_pkg.sv
// Shared types and constants for the nearest palette index mapper.
// Holds field widths, command and register codes, and the lane record.
// No dependencies; every other file of the block imports it.
package npim_pkg;

  localparam int COLOR_W  = 8;
  localparam int INDEX_W  = 4;
  localparam int WANT_W   = 17;
  localparam int LIMIT_W  = 14;
  localparam int SIZE_W   = 5;
  localparam int DIST_W   = 32;

  localparam int S_TDATA_W  = 104;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 32;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Channel order used by every per-channel array.
  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Luminance weights; they add up to 1 << WEIGHT_SUM_W.
  localparam int WEIGHT_SUM_W = 6;
  localparam int unsigned WEIGHT_RED   = 19;
  localparam int unsigned WEIGHT_GREEN = 37;
  localparam int unsigned WEIGHT_BLUE  = (1 << WEIGHT_SUM_W) - WEIGHT_RED - WEIGHT_GREEN;

  localparam logic [LIMIT_W-1:0] DIFFUSE_LIMIT_RESET = 14'd1024;
  localparam logic [SIZE_W-1:0]  PALETTE_SIZE_RESET  = 5'd16;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_DIFFUSE_LIMIT = 1'b0,
    REG_PALETTE_SIZE  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    rgb_t               color;
  } entry_t;

  typedef struct packed {
    logic signed [WANT_W-1:0] red;
    logic signed [WANT_W-1:0] green;
    logic signed [WANT_W-1:0] blue;
  } want_t;

  // One palette lane after the distance stages.
  typedef struct packed {
    logic              en;
    logic [DIST_W-1:0] score;
    rgb_t              color;
  } lane_t;

endpackage

>>> rtl/npim_clamp.sv
// First pipeline stage: limits each channel's deviation from the source pixel.
// Depends on npim_pkg for field types and channel order.
module npim_clamp #(
  parameter int FRAC_BITS = 8,
  localparam int TGT_W = (((FRAC_BITS + 9) > 17) ? (FRAC_BITS + 9) : 17) + 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  npim_pkg::cmd_t                         in_cmd,
  input  npim_pkg::entry_t                       in_entry,
  input  npim_pkg::want_t                        in_want,
  input  npim_pkg::rgb_t                         in_src,
  input  logic [npim_pkg::LIMIT_W-1:0]           diffuse_limit,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output npim_pkg::cmd_t                         out_cmd,
  output npim_pkg::entry_t                       out_entry,
  output logic [npim_pkg::NUM_CH-1:0][TGT_W-1:0] out_target
);
  import npim_pkg::*;

  logic signed [TGT_W-1:0] bound;

  // The wanted value is pulled back to within bound of the scaled source.
  function automatic logic signed [TGT_W-1:0] limit_channel(
    input logic signed [WANT_W-1:0] want,
    input logic [COLOR_W-1:0]       src,
    input logic signed [TGT_W-1:0]  lim
  );
    logic signed [TGT_W-1:0] base;
    logic signed [TGT_W-1:0] dev;
    base = $signed(TGT_W'(src) << FRAC_BITS);
    dev  = TGT_W'(want) - base;
    if (dev < -lim) begin
      dev = -lim;
    end else if (dev > lim) begin
      dev = lim;
    end
    return base + dev;
  endfunction

  assign bound    = $signed(TGT_W'(diffuse_limit >> 1));
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_cmd              <= in_cmd;
      out_entry            <= in_entry;
      out_target[CH_RED]   <= limit_channel(in_want.red, in_src.red, bound);
      out_target[CH_GREEN] <= limit_channel(in_want.green, in_src.green, bound);
      out_target[CH_BLUE]  <= limit_channel(in_want.blue, in_src.blue, bound);
    end
  end

endmodule

>>> rtl/npim_lanes.sv
// Palette registers and one distance lane per entry, three register stages:
// absolute difference, square, weighted sum. Depends on npim_pkg.
module npim_lanes #(
  parameter int PALETTE_DEPTH = 16,
  parameter int FRAC_BITS = 8,
  localparam int TGT_W = (((FRAC_BITS + 9) > 17) ? (FRAC_BITS + 9) : 17) + 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  npim_pkg::cmd_t                         in_cmd,
  input  npim_pkg::entry_t                       in_entry,
  input  logic [npim_pkg::NUM_CH-1:0][TGT_W-1:0] in_target,
  input  logic [npim_pkg::SIZE_W-1:0]            palette_size,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output npim_pkg::lane_t                        out_lane [PALETTE_DEPTH]
);
  import npim_pkg::*;

  localparam int DIFF_W = TGT_W + 1;
  localparam int MAG_W  = TGT_W - 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + WEIGHT_SUM_W;

  logic b_v, c_v;
  logic b_ready, c_ready, d_ready;

  rgb_t pal [PALETTE_DEPTH];

  logic             b_en    [PALETTE_DEPTH];
  rgb_t             b_color [PALETTE_DEPTH];
  logic [MAG_W-1:0] b_mag   [PALETTE_DEPTH][NUM_CH];
  logic             c_en    [PALETTE_DEPTH];
  rgb_t             c_color [PALETTE_DEPTH];
  logic [SQ_W-1:0]  c_sq    [PALETTE_DEPTH][NUM_CH];

  function automatic logic [COLOR_W-1:0] channel(input rgb_t c, input int k);
    case (k)
      CH_RED:   return c.red;
      CH_GREEN: return c.green;
      default:  return c.blue;
    endcase
  endfunction

  assign d_ready  = !out_valid || out_ready;
  assign c_ready  = !c_v || d_ready;
  assign b_ready  = !b_v || c_ready;
  assign in_ready = b_ready;

  // Load items end here: they write the palette on the edge where a map
  // item at the same place would sample it, which keeps program order.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_ready) begin
        b_v <= in_valid && (in_cmd == CMD_MAP);
      end
      if (c_ready) begin
        c_v <= b_v;
      end
      if (d_ready) begin
        out_valid <= c_v;
      end
    end
  end

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_lane
    logic signed [DIFF_W-1:0] diff [NUM_CH];
    logic [MAG_W-1:0]         mag  [NUM_CH];
    logic [SUM_W-1:0]         wsum;
    logic                     lane_on;

    assign lane_on = (i == 0) || (i < int'(palette_size));

    always_ff @(posedge clk) begin
      if (in_valid && b_ready && (in_cmd == CMD_LOAD) && (int'(in_entry.index) == i)) begin
        pal[i] <= in_entry.color;
      end
    end

    always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
        diff[k] = $signed(DIFF_W'(channel(pal[i], k)) << FRAC_BITS)
                - DIFF_W'($signed(in_target[k]));
        mag[k]  = diff[k][DIFF_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
      end
    end

    assign wsum = SUM_W'(c_sq[i][CH_RED])   * SUM_W'(WEIGHT_RED)
                + SUM_W'(c_sq[i][CH_GREEN]) * SUM_W'(WEIGHT_GREEN)
                + SUM_W'(c_sq[i][CH_BLUE])  * SUM_W'(WEIGHT_BLUE);

    always_ff @(posedge clk) begin
      if (b_ready) begin
        b_en[i]    <= lane_on;
        b_color[i] <= pal[i];
        for (int k = 0; k < NUM_CH; k++) begin
          b_mag[i][k] <= mag[k];
        end
      end
      if (c_ready) begin
        c_en[i]    <= b_en[i];
        c_color[i] <= b_color[i];
        for (int k = 0; k < NUM_CH; k++) begin
          c_sq[i][k] <= SQ_W'(b_mag[i][k]) * SQ_W'(b_mag[i][k]);
        end
      end
      if (d_ready) begin
        out_lane[i].en    <= c_en[i];
        out_lane[i].score <= DIST_W'(wsum >> (2 * FRAC_BITS));
        out_lane[i].color <= c_color[i];
      end
    end
  end

endmodule

>>> rtl/npim_min_tree.sv
// Registered minimum tree over the lane distances, one tree level per stage.
// The lower index wins ties; disabled lanes never win. Depends on npim_pkg.
module npim_min_tree #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  npim_pkg::lane_t               in_lane [PALETTE_DEPTH],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [npim_pkg::INDEX_W-1:0]  out_slot,
  output npim_pkg::rgb_t                out_color
);
  import npim_pkg::*;

  localparam int LEVELS = $clog2(PALETTE_DEPTH);
  localparam int LEAVES = 1 << LEVELS;

  typedef struct packed {
    logic              en;
    logic [DIST_W-1:0] score;
    logic [LEVELS-1:0] idx;
    rgb_t              color;
  } node_t;

  node_t leaf   [LEAVES];
  node_t node_q [1:LEAVES-1];

  logic [LEVELS-1:0] lvl_v;
  logic [LEVELS-1:0] lvl_ready;

  function automatic node_t pick(input node_t l, input node_t r);
    if (r.en && (!l.en || (r.score < l.score))) begin
      return r;
    end
    return l;
  endfunction

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < PALETTE_DEPTH) begin : g_real
      assign leaf[i] = {in_lane[i].en, in_lane[i].score, LEVELS'(i), in_lane[i].color};
    end else begin : g_pad
      assign leaf[i] = {1'b0, {DIST_W{1'b0}}, LEVELS'(i), {(3 * COLOR_W){1'b0}}};
    end
  end

  for (genvar s = 0; s < LEVELS; s++) begin : g_stage
    if (s == LEVELS - 1) begin : g_last
      assign lvl_ready[s] = !lvl_v[s] || out_ready;
    end else begin : g_mid
      assign lvl_ready[s] = !lvl_v[s] || lvl_ready[s+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lvl_v[s] <= 1'b0;
      end else if (lvl_ready[s]) begin
        if (s == 0) begin
          lvl_v[s] <= in_valid;
        end else begin
          lvl_v[s] <= lvl_v[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  // Heap numbering: node j combines 2j and 2j+1; the root is node 1.
  for (genvar j = 1; j < LEAVES; j++) begin : g_node
    localparam int STG = LEVELS - $clog2(j + 1);
    node_t l_n, r_n;

    if (2 * j >= LEAVES) begin : g_from_leaf
      assign l_n = leaf[2 * j - LEAVES];
      assign r_n = leaf[2 * j + 1 - LEAVES];
    end else begin : g_from_node
      assign l_n = node_q[2 * j];
      assign r_n = node_q[2 * j + 1];
    end

    always_ff @(posedge clk) begin
      if (lvl_ready[STG]) begin
        node_q[j] <= pick(l_n, r_n);
      end
    end
  end

  assign in_ready  = lvl_ready[0];
  assign out_valid = lvl_v[LEVELS-1];
  assign out_slot  = INDEX_W'(node_q[1].idx);
  assign out_color = node_q[1].color;

endmodule

>>> rtl/nearest_palette_index_mapper_top.sv
// Top level of the nearest palette index mapper: stream ports, APB registers,
// and the clamp, distance lane and minimum tree pipeline. Uses npim_pkg.
//
// Channel   Direction  Beat contents
// s_*       in         load a palette entry or map one pixel (cmd in tuser)
// m_*       out        palette index and chosen color, one per map beat
// APB       in/out     diffuse_limit at 0x0, palette_size at 0x4
//
// One beat enters per cycle when nothing downstream stalls. A map beat passes
// one clamp stage, three distance lane stages and one stage per tree level
// before it comes out. Load beats write the palette and produce nothing.
// Reset clears the valid bits and sets the registers to their reset values;
// the palette itself is not cleared. A stall on m_tready holds each stage in
// place, and empty stages still fill behind it.
module nearest_palette_index_mapper_top #(
  parameter int PALETTE_DEPTH = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // Slave stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata from bit 0 up: entry_index[3:0], entry_red[11:4], entry_green[19:12],
  // entry_blue[27:20], want_red[44:28], want_green[61:45], want_blue[78:62],
  // src_red[86:79], src_green[94:87], src_blue[102:95], zero pad[103].
  input  logic [npim_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser: cmd[0] (0 load, 1 map).
  input  logic [npim_pkg::S_TUSER_W-1:0]    s_tuser,
  // Master stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata from bit 0 up: palette_index[3:0], chosen_red[11:4],
  // chosen_green[19:12], chosen_blue[27:20], zero pad[31:28].
  output logic [npim_pkg::M_TDATA_W-1:0]    m_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [npim_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [npim_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [npim_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import npim_pkg::*;

  localparam int TGT_W = (((FRAC_BITS + 9) > 17) ? (FRAC_BITS + 9) : 17) + 1;

  logic [LIMIT_W-1:0] diffuse_limit;
  logic [SIZE_W-1:0]  palette_size;
  logic               cfg_write;
  reg_index_t         cfg_reg;

  cmd_t   in_cmd;
  entry_t in_entry;
  want_t  in_want;
  rgb_t   in_src;

  logic                         a_valid, a_ready;
  cmd_t                         a_cmd;
  entry_t                       a_entry;
  logic [NUM_CH-1:0][TGT_W-1:0] a_target;

  logic  d_valid, d_ready;
  lane_t d_lane [PALETTE_DEPTH];

  logic [INDEX_W-1:0] res_index;
  rgb_t               res_color;

  // Registers sit at word addresses, so bit 2 alone picks one.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_reg   = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      diffuse_limit <= DIFFUSE_LIMIT_RESET;
      palette_size  <= PALETTE_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_reg)
        REG_DIFFUSE_LIMIT: diffuse_limit <= pwdata[LIMIT_W-1:0];
        REG_PALETTE_SIZE:  palette_size  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_DIFFUSE_LIMIT: prdata = APB_DATA_W'(diffuse_limit);
      REG_PALETTE_SIZE:  prdata = APB_DATA_W'(palette_size);
      default:           prdata = '0;
    endcase
  end

  // Unpack the input beat.
  assign in_cmd            = cmd_t'(s_tuser[0]);
  assign in_entry.index    = s_tdata[3:0];
  assign in_entry.color    = {s_tdata[11:4], s_tdata[19:12], s_tdata[27:20]};
  assign in_want.red       = $signed(s_tdata[44:28]);
  assign in_want.green     = $signed(s_tdata[61:45]);
  assign in_want.blue      = $signed(s_tdata[78:62]);
  assign in_src            = {s_tdata[86:79], s_tdata[94:87], s_tdata[102:95]};

  npim_clamp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_clamp (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_cmd        (in_cmd),
    .in_entry      (in_entry),
    .in_want       (in_want),
    .in_src        (in_src),
    .diffuse_limit (diffuse_limit),
    .out_valid     (a_valid),
    .out_ready     (a_ready),
    .out_cmd       (a_cmd),
    .out_entry     (a_entry),
    .out_target    (a_target)
  );

  // The palette is written and read inside the lanes at one stage, so a
  // load that follows a map never changes the colors that map compares.
  npim_lanes #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_lanes (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (a_valid),
    .in_ready     (a_ready),
    .in_cmd       (a_cmd),
    .in_entry     (a_entry),
    .in_target    (a_target),
    .palette_size (palette_size),
    .out_valid    (d_valid),
    .out_ready    (d_ready),
    .out_lane     (d_lane)
  );

  // The root of the tree is the output register of the block.
  npim_min_tree #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_tree (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_lane   (d_lane),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_slot  (res_index),
    .out_color (res_color)
  );

  assign m_tdata = {4'b0000, res_color.blue, res_color.green, res_color.red, res_index};

endmodule
